[src/rcp_pkg.sv]
`default_nettype none

package rcp_pkg;

    localparam int WORD_W     = 32;
    localparam int GRID_W     = 11;
    localparam int COORD_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int ITER_W     = 6;

    localparam logic [GRID_W-1:0] GRID_RESET = 11'd32;

    localparam logic OP_PICK  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [STATUS_W-1:0] ST_PICKED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_DIVK,
        S_RDK,
        S_RDL,
        S_WR,
        S_DIVC,
        S_OUT
    } rcp_state_t;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
    } rcp_div_ctl_t;

endpackage

`default_nettype wire

[src/rcp_if.sv]
`default_nettype none

interface rcp_in_if import rcp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [WORD_W-1:0] random_word;

    modport source (output valid, output opcode, output random_word, input ready);
    modport sink   (input valid, input opcode, input random_word, output ready);
endinterface

interface rcp_out_if import rcp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COORD_W-1:0]  cell_row;
    logic [COORD_W-1:0]  cell_col;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output cell_row, output cell_col, output status,
                    input ready);
    modport sink   (input valid, input cell_row, input cell_col, input status,
                    output ready);
endinterface

interface rcp_cfg_if import rcp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GRID_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/rcp_ram.sv]
`default_nettype none

module rcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/rcp_div.sv]
`default_nettype none

// restoring divider, one quotient bit per cycle from the msb of the dividend
module rcp_div import rcp_pkg::*; #(
    parameter int DVW = 11
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rcp_div_ctl_t       ctl,
    input  wire logic [WORD_W-1:0]  dividend,
    input  wire logic [DVW-1:0]     divisor,
    output logic                    done,
    output logic [WORD_W-1:0]       quotient,
    output logic [DVW-1:0]          remainder
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic [DVW-1:0]    rem_reg, rem_next;
    logic [DVW-1:0]    dvs_reg, dvs_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [DVW:0]      shifted;
    logic [DVW:0]      diff;
    logic              fits;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[WORD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        fits      = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ctl.iters;
            rem_next  = '0;
            dvs_next  = divisor;
            dvd_next  = dividend;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVW-1:0] : shifted[DVW-1:0];
            quo_next = {quo_reg[WORD_W-2:0], fits};
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a finished run");
`endif

endmodule

`default_nettype wire

[src/random_cell_picker_without_replacement.sv]
`default_nettype none

// random cell picker without replacement over a grid_rows by grid_cols grid
// pick_in words carry an opcode and a random word; pick_in.ready is high
// only while the block is idle, one item is worked on at a time
// a pick answers one pick_out word: row and column of an unused cell, or
// the exhausted status when no cell remains; a clear answers cleared status
// a pick runs the bit-serial divider, which first takes random mod remaining
// and then splits the cell by grid_cols, with remap table access between
// a clear runs a wipe of the table, one table entry wiped per cycle
// after reset the same wipe runs with pick_in.ready low;
// cfg writes (grid_rows index 0, grid_cols index 1) are taken at any time
// pick_out is a result register: a stalled receiver holds the word there
// while the next item is accepted and worked on; that item waits only for
// the register to free up before its own word is loaded
module random_cell_picker_without_replacement import rcp_pkg::*; #(
    parameter int MAX_CELLS = 1024
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rcp_cfg_if.sink   cfg,
    rcp_in_if.sink    pick_in,
    rcp_out_if.source pick_out
);

    // slot address width, live count width, divider width
    localparam int AW      = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int RW      = $clog2(MAX_CELLS + 1);
    localparam int DVW     = (RW > GRID_W) ? RW : GRID_W;
    localparam int PROD_W  = 2 * GRID_W;
    localparam int RESET_COUNT = (32 * 32 > MAX_CELLS) ? MAX_CELLS : 32 * 32;
    localparam logic [PROD_W-1:0] MAX_PROD = PROD_W'(MAX_CELLS);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(MAX_CELLS - 1);

    rcp_state_t           state_reg, state_next;
    logic [GRID_W-1:0]    rows_reg, rows_next;
    logic [GRID_W-1:0]    cols_reg, cols_next;
    logic [RW-1:0]        remaining_reg, remaining_next;
    logic                 clr_pending_reg, clr_pending_next;
    logic [AW-1:0]        sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]        k_reg, k_next;
    logic [AW-1:0]        cell_reg, cell_next;
    logic [COORD_W-1:0]   res_row_reg, res_row_next;
    logic [COORD_W-1:0]   res_col_reg, res_col_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]   out_row_reg, out_row_next;
    logic [COORD_W-1:0]   out_col_reg, out_col_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;

    // remap table: valid mark in the msb, mapped cell below
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW:0]          ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [AW:0]          ram_rdata;
    logic [AW-1:0]        ram_cell;
    // address of the word now on ram_rdata, to resolve an unmapped slot
    logic [AW-1:0]        ram_raddr_q;

    rcp_div_ctl_t         div_ctl;
    logic [WORD_W-1:0]    div_dividend;
    logic [DVW-1:0]       div_divisor;
    logic                 div_done;
    logic [WORD_W-1:0]    div_quotient;
    logic [DVW-1:0]       div_remainder;

    logic [PROD_W-1:0]    grid_prod;
    logic [RW-1:0]        full_count;
    logic [AW-1:0]        last_slot;
    logic                 in_fire;
    logic                 out_free;

    rcp_ram #(
        .WIDTH (AW + 1),
        .DEPTH (MAX_CELLS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rcp_div #(
        .DVW (DVW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // full count clamps an oversized grid to the table size
    assign grid_prod  = PROD_W'(rows_reg) * PROD_W'(cols_reg);
    assign full_count = (grid_prod > MAX_PROD) ? RW'(MAX_CELLS) : grid_prod[RW-1:0];
    assign last_slot  = AW'(remaining_reg - RW'(1));
    // an unmapped slot stands for itself
    assign ram_cell   = ram_rdata[AW] ? ram_rdata[AW-1:0] : ram_raddr_q;

    always_ff @(posedge clk)
    begin
        ram_raddr_q <= ram_raddr;
    end

    assign cfg.ready     = 1'b1;
    assign pick_in.ready = (state_reg == S_IDLE);
    assign in_fire       = pick_in.valid && pick_in.ready;
    assign out_free      = !out_valid_reg || pick_out.ready;

    always_comb
    begin
        state_next       = state_reg;
        rows_next        = rows_reg;
        cols_next        = cols_reg;
        remaining_next   = remaining_reg;
        clr_pending_next = clr_pending_reg;
        sweep_addr_next  = sweep_addr_reg;
        k_next           = k_reg;
        cell_next        = cell_reg;
        res_row_next     = res_row_reg;
        res_col_next     = res_col_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && !pick_out.ready;
        out_row_next     = out_row_reg;
        out_col_next     = out_col_reg;
        out_status_next  = out_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = k_reg;
        ram_wdata        = {1'b1, ram_cell};
        ram_raddr        = k_reg;
        div_ctl.start    = 1'b0;
        div_ctl.iters    = ITER_W'(WORD_W);
        div_dividend     = pick_in.random_word;
        div_divisor      = DVW'(remaining_reg);

        // register writes, unknown indexes dropped
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_GRID_ROWS: rows_next = cfg.data;
                REG_GRID_COLS: cols_next = cfg.data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_SWEEP:
            begin
                // wipe one valid mark per cycle
                ram_we          = 1'b1;
                ram_waddr       = sweep_addr_reg;
                ram_wdata       = '0;
                sweep_addr_next = sweep_addr_reg + AW'(1);
                if (sweep_addr_reg == LAST_ADDR)
                begin
                    sweep_addr_next = '0;
                    if (clr_pending_reg)
                    begin
                        clr_pending_next = 1'b0;
                        remaining_next   = full_count;
                        res_row_next     = '0;
                        res_col_next     = '0;
                        res_status_next  = ST_CLEARED;
                        state_next       = S_OUT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (pick_in.opcode == OP_CLEAR)
                    begin
                        clr_pending_next = 1'b1;
                        sweep_addr_next  = '0;
                        state_next       = S_SWEEP;
                    end
                    else if (remaining_reg == '0)
                    begin
                        res_row_next    = '0;
                        res_col_next    = '0;
                        res_status_next = ST_EXHAUSTED;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        // k = random mod remaining
                        div_ctl.start = 1'b1;
                        state_next    = S_DIVK;
                    end
                end
            end
            S_DIVK:
            begin
                if (div_done)
                begin
                    k_next     = div_remainder[AW-1:0];
                    state_next = S_RDK;
                end
            end
            S_RDK:
            begin
                ram_raddr  = k_reg;
                state_next = S_RDL;
            end
            S_RDL:
            begin
                // slot k comes back while the last live slot is read
                ram_raddr  = last_slot;
                cell_next  = ram_cell;
                state_next = S_WR;
            end
            S_WR:
            begin
                // slot k takes over the cell of the last live slot
                ram_we         = 1'b1;
                ram_waddr      = k_reg;
                ram_wdata      = {1'b1, ram_cell};
                remaining_next = remaining_reg - RW'(1);
                if (cols_reg == '0)
                begin
                    res_row_next    = '0;
                    res_col_next    = '0;
                    res_status_next = ST_PICKED;
                    state_next      = S_OUT;
                end
                else
                begin
                    // only the cell bits go through the divider
                    div_ctl.start = 1'b1;
                    div_ctl.iters = ITER_W'(AW);
                    div_dividend  = {cell_reg, {(WORD_W - AW){1'b0}}};
                    div_divisor   = DVW'(cols_reg);
                    state_next    = S_DIVC;
                end
            end
            S_DIVC:
            begin
                if (div_done)
                begin
                    res_row_next    = div_quotient[COORD_W-1:0];
                    res_col_next    = div_remainder[COORD_W-1:0];
                    res_status_next = ST_PICKED;
                    state_next      = S_OUT;
                end
            end
            S_OUT:
            begin
                // wait for the result register to free up
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_row_next    = res_row_reg;
                    out_col_next    = res_col_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            rows_reg        <= GRID_RESET;
            cols_reg        <= GRID_RESET;
            remaining_reg   <= RW'(RESET_COUNT);
            clr_pending_reg <= 1'b0;
            sweep_addr_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rows_reg        <= rows_next;
            cols_reg        <= cols_next;
            remaining_reg   <= remaining_next;
            clr_pending_reg <= clr_pending_next;
            sweep_addr_reg  <= sweep_addr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        cell_reg       <= cell_next;
        res_row_reg    <= res_row_next;
        res_col_reg    <= res_col_next;
        res_status_reg <= res_status_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_status_reg <= out_status_next;
    end

    assign pick_out.valid    = out_valid_reg;
    assign pick_out.cell_row = out_row_reg;
    assign pick_out.cell_col = out_col_reg;
    assign pick_out.status   = out_status_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg <= RW'(MAX_CELLS))
        else $error("live count above table size");
    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> !pick_in.ready)
        else $error("input taken during table wipe");
    a_k_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> (RW'(k_reg) < remaining_reg))
        else $error("remapped slot outside live range");
    a_remap_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg != S_SWEEP)) |-> ram_wdata[AW])
        else $error("remap write without valid mark");
`endif

endmodule

`default_nettype wire
